// ===== hdl/sda_pkg.sv =====
// Shared constants, types and state encoding for the signed decimal adder.
`default_nettype none

package sda_pkg;

   localparam int MAX_DIGITS = 1024;
   localparam int DIGIT_W    = 4;
   localparam int DIG_AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int LEN_W      = $clog2(MAX_DIGITS + 1);
   localparam int SUM_DEPTH  = MAX_DIGITS + 1;
   localparam int RADIX      = 10;

   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = DIGIT_W'(0);
   localparam logic [DIGIT_W-1:0] DIGIT_ONE  = DIGIT_W'(1);
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(RADIX - 1);

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMP_RD,
      S_CMP_EX,
      S_ALU_RD,
      S_ALU_EX,
      S_CARRY,
      S_FIN,
      S_RD_ADDR,
      S_RD_DATA
   } state_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               cout;
      logic               gt;
      logic               lt;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== hdl/sda_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
`default_nettype none

module sda_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/sda_digit_alu.sv =====
// Shared decimal digit unit: add with carry, subtract with borrow, and compare.
`default_nettype none

module sda_digit_alu (
   input  wire logic [sda_pkg::DIGIT_W-1:0] x,
   input  wire logic [sda_pkg::DIGIT_W-1:0] y,
   input  wire logic                        cin,
   input  wire logic                        sub,
   output sda_pkg::alu_res_type             res
);

   import sda_pkg::*;

   logic [DIGIT_W:0] sum;
   logic [DIGIT_W:0] ysub;
   logic [DIGIT_W:0] xw;

   always_comb begin
      xw   = {1'b0, x};
      sum  = xw + {1'b0, y} + {{DIGIT_W{1'b0}}, cin};
      ysub = {1'b0, y} + {{DIGIT_W{1'b0}}, cin};
      res.gt = (x > y);
      res.lt = (x < y);
      if (sub) begin
         if (xw >= ysub) begin
            res.digit = DIGIT_W'(xw - ysub);
            res.cout  = 1'b0;
         end else begin
            res.digit = DIGIT_W'(xw + (DIGIT_W + 1)'(RADIX) - ysub);
            res.cout  = 1'b1;
         end
      end else begin
         if (sum >= (DIGIT_W + 1)'(RADIX)) begin
            res.digit = DIGIT_W'(sum - (DIGIT_W + 1)'(RADIX));
            res.cout  = 1'b1;
         end else begin
            res.digit = DIGIT_W'(sum);
            res.cout  = 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/signed_decimal_adder_unit.sv =====
// Top level of the signed decimal adder: digit stores, sequencer and result register.
// Load words are taken while idle. A read word, once the sum exists, passes through an
// address state and a data state. The first read after loading also runs the sum pass
// through the one shared digit unit: a read and an execute state per digit of the longer
// operand (the operand memories have a registered read port), the same again at most
// for the magnitude compare when signs differ, then a carry state and a closing state.
`default_nettype none

module signed_decimal_adder_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_opcode,
   input  wire logic [sda_pkg::DIGIT_W-1:0] req_digit_in,
   input  wire logic                        req_negative_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [sda_pkg::DIGIT_W-1:0] rsp_digit_out,
   output logic                             rsp_negative_out,
   output logic                             rsp_last_out,
   output logic                             rsp_overflow_out
);

   import sda_pkg::*;

   state_type state_ff, state_in;

   logic [LEN_W-1:0] a_len_ff, a_len_in, b_len_ff, b_len_in;
   logic             a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic             dropped_ff, dropped_in, computed_ff, computed_in;
   logic [LEN_W-1:0] sum_len_ff, sum_len_in, rp_ff, rp_in;
   logic             sum_neg_ff, sum_neg_in;
   logic [LEN_W-1:0] width_ff, width_in, pos_ff, pos_in, top_ff, top_in;
   logic             carry_ff, carry_in, a_big_ff, a_big_in, nz_ff, nz_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] rsp_digit_ff, rsp_digit_in;
   logic             rsp_neg_ff, rsp_neg_in, rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic             accept, out_free, rsp_load, is_last, signs_differ;
   logic [LEN_W-1:0] len_max;
   logic [DIGIT_W-1:0] digit_sat, da, db;

   logic               a_we, b_we, s_we;
   logic [DIG_AW-1:0]  a_waddr, b_waddr, a_raddr, b_raddr;
   logic [LEN_W-1:0]   s_waddr, s_raddr;
   logic [DIGIT_W-1:0] s_wdata, a_q, b_q, s_q;

   logic [DIGIT_W-1:0] alu_x, alu_y;
   alu_res_type        alu_res;

   sda_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_a_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(digit_sat),
      .rd_addr(a_raddr), .rd_data(a_q)
   );

   sda_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_b_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(digit_sat),
      .rd_addr(b_raddr), .rd_data(b_q)
   );

   sda_ram #(.WIDTH(DIGIT_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_q)
   );

   sda_digit_alu u_alu (
      .x(alu_x), .y(alu_y), .cin(carry_ff), .sub(signs_differ), .res(alu_res)
   );

   assign req_stall        = (state_ff != S_IDLE);
   assign accept           = req_valid && !req_stall;
   assign out_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_load         = (state_ff == S_RD_DATA) && out_free;
   assign is_last          = ((rp_ff + LEN_W'(1)) == sum_len_ff);
   assign signs_differ     = (a_neg_ff != b_neg_ff);
   assign len_max          = (a_len_ff > b_len_ff) ? a_len_ff : b_len_ff;
   assign digit_sat        = (req_digit_in > DIGIT_MAX) ? DIGIT_MAX : req_digit_in;
   assign da               = (pos_ff < a_len_ff) ? a_q : DIGIT_ZERO;
   assign db               = (pos_ff < b_len_ff) ? b_q : DIGIT_ZERO;
   assign alu_x            = a_big_ff ? da : db;
   assign alu_y            = a_big_ff ? db : da;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_out    = rsp_digit_ff;
   assign rsp_negative_out = rsp_neg_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow_out = rsp_ovf_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_READ)) begin
               if (computed_ff) begin
                  state_in = S_RD_ADDR;
               end else if (len_max == '0) begin
                  state_in = S_FIN;
               end else if (signs_differ) begin
                  state_in = S_CMP_RD;
               end else begin
                  state_in = S_ALU_RD;
               end
            end
         end
         S_CMP_RD: state_in = S_CMP_EX;
         S_CMP_EX: begin
            if (alu_res.gt || alu_res.lt || (pos_ff == '0)) begin
               state_in = S_ALU_RD;
            end else begin
               state_in = S_CMP_RD;
            end
         end
         S_ALU_RD: state_in = S_ALU_EX;
         S_ALU_EX: begin
            if (pos_ff == (width_ff - LEN_W'(1))) begin
               state_in = (!signs_differ && alu_res.cout) ? S_CARRY : S_FIN;
            end else begin
               state_in = S_ALU_RD;
            end
         end
         S_CARRY:   state_in = S_FIN;
         S_FIN:     state_in = S_RD_ADDR;
         S_RD_ADDR: state_in = S_RD_DATA;
         S_RD_DATA: state_in = out_free ? S_IDLE : S_RD_DATA;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      a_we    = 1'b0;
      b_we    = 1'b0;
      s_we    = 1'b0;
      a_waddr = a_len_ff[DIG_AW-1:0];
      b_waddr = b_len_ff[DIG_AW-1:0];
      a_raddr = DIG_AW'(a_len_ff - LEN_W'(1) - pos_ff);
      b_raddr = DIG_AW'(b_len_ff - LEN_W'(1) - pos_ff);
      s_waddr = pos_ff;
      s_wdata = alu_res.digit;
      s_raddr = sum_len_ff - LEN_W'(1) - rp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !computed_ff) begin
               a_we = (req_opcode == OP_LOAD_A) && (a_len_ff < LEN_W'(MAX_DIGITS));
               b_we = (req_opcode == OP_LOAD_B) && (b_len_ff < LEN_W'(MAX_DIGITS));
            end
         end
         S_ALU_EX: s_we = 1'b1;
         S_CARRY: begin
            s_we    = 1'b1;
            s_waddr = width_ff;
            s_wdata = DIGIT_ONE;
         end
         S_CMP_RD, S_CMP_EX, S_ALU_RD, S_FIN, S_RD_ADDR, S_RD_DATA: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      a_len_in     = a_len_ff;
      b_len_in     = b_len_ff;
      a_neg_in     = a_neg_ff;
      b_neg_in     = b_neg_ff;
      dropped_in   = dropped_ff;
      computed_in  = computed_ff;
      sum_len_in   = sum_len_ff;
      sum_neg_in   = sum_neg_ff;
      rp_in        = rp_ff;
      width_in     = width_ff;
      pos_in       = pos_ff;
      top_in       = top_ff;
      carry_in     = carry_ff;
      a_big_in     = a_big_ff;
      nz_in        = nz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_digit_in = rsp_digit_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !computed_ff && (req_opcode == OP_LOAD_A)) begin
               a_neg_in = req_negative_in;
               if (a_we) begin
                  a_len_in = a_len_ff + LEN_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            if (accept && !computed_ff && (req_opcode == OP_LOAD_B)) begin
               b_neg_in = req_negative_in;
               if (b_we) begin
                  b_len_in = b_len_ff + LEN_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            if (accept && !computed_ff && (req_opcode == OP_READ)) begin
               width_in = len_max;
               carry_in = 1'b0;
               a_big_in = 1'b1;
               nz_in    = 1'b0;
               top_in   = '0;
               pos_in   = signs_differ ? (len_max - LEN_W'(1)) : '0;
            end
         end
         S_CMP_EX: begin
            if (alu_res.gt || alu_res.lt || (pos_ff == '0)) begin
               a_big_in = !alu_res.lt;
               pos_in   = '0;
            end else begin
               pos_in = pos_ff - LEN_W'(1);
            end
         end
         S_ALU_EX: begin
            carry_in = alu_res.cout;
            pos_in   = pos_ff + LEN_W'(1);
            if (alu_res.digit != DIGIT_ZERO) begin
               nz_in  = 1'b1;
               top_in = pos_ff;
            end
         end
         S_CARRY: begin
            nz_in  = 1'b1;
            top_in = width_ff;
         end
         S_FIN: begin
            sum_len_in  = nz_ff ? (top_ff + LEN_W'(1)) : LEN_W'(1);
            sum_neg_in  = nz_ff && (a_big_ff ? a_neg_ff : b_neg_ff);
            computed_in = 1'b1;
            rp_in       = '0;
         end
         S_RD_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_digit_in = nz_ff ? s_q : DIGIT_ZERO;
               rsp_neg_in   = sum_neg_ff;
               rsp_last_in  = is_last;
               rsp_ovf_in   = dropped_ff;
               if (is_last) begin
                  a_len_in    = '0;
                  b_len_in    = '0;
                  a_neg_in    = 1'b0;
                  b_neg_in    = 1'b0;
                  dropped_in  = 1'b0;
                  computed_in = 1'b0;
                  sum_len_in  = '0;
                  sum_neg_in  = 1'b0;
                  rp_in       = '0;
               end else begin
                  rp_in = rp_ff + LEN_W'(1);
               end
            end
         end
         S_CMP_RD, S_ALU_RD, S_RD_ADDR: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_len_ff     <= '0;
         b_len_ff     <= '0;
         a_neg_ff     <= 1'b0;
         b_neg_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         computed_ff  <= 1'b0;
         sum_len_ff   <= '0;
         sum_neg_ff   <= 1'b0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_len_ff     <= a_len_in;
         b_len_ff     <= b_len_in;
         a_neg_ff     <= a_neg_in;
         b_neg_ff     <= b_neg_in;
         dropped_ff   <= dropped_in;
         computed_ff  <= computed_in;
         sum_len_ff   <= sum_len_in;
         sum_neg_ff   <= sum_neg_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff     <= width_in;
      pos_ff       <= pos_in;
      top_ff       <= top_in;
      carry_ff     <= carry_in;
      a_big_ff     <= a_big_in;
      nz_ff        <= nz_in;
      rsp_digit_ff <= rsp_digit_in;
      rsp_neg_ff   <= rsp_neg_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && is_last) |=> ((a_len_ff == '0) && (b_len_ff == '0) && !computed_ff))
      else $error("Operands were not cleared after the last result word.");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      computed_ff |-> ((sum_len_ff != '0) && (rp_ff < sum_len_ff)))
      else $error("Read pointer is outside the stored sum.");

   a_pass_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALU_EX) |-> (pos_ff < width_ff))
      else $error("Digit pass ran past the operand width.");

endmodule

`default_nettype wire
